[rtl/cmf_pkg.sv]
package cmf_pkg;

    // field widths of one item
    localparam int KIND_W    = 16;
    localparam int ID_W      = 16;
    localparam int BYTE_W    = 8;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int TDATA_W   = 40;
    localparam int TUSER_W   = 3;

    // action codes of an input item
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD     = 2'd0,
        ACT_REPLACE = 2'd1,
        ACT_TAKE    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // status codes of a result item
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 2'd0,
        ST_REJECTED = 2'd1,
        ST_BYTE_OUT = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_OPEN_NEW,
        S_BYTE,
        S_RESULT,
        S_TAKE_RD,
        S_TAKE_OUT
    } t_state;

endpackage

[rtl/cmf_ram.sv]
module cmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/cmf_slot_unit.sv]
module cmf_slot_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] i_base,
    input  logic [$clog2(QUEUE_DEPTH + 1)-1:0]                       i_offset,
    output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] o_slot
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW:0] sum;
    logic [CW:0] wrapped;

    // ring position: base plus offset, wrapped once past the queue depth
    always_comb begin
        sum     = (CW + 1)'(i_base) + (CW + 1)'(i_offset);
        wrapped = sum - (CW + 1)'(QUEUE_DEPTH);
        if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
            o_slot = QW'(wrapped);
        end else begin
            o_slot = QW'(sum);
        end
    end

endmodule

[rtl/coalescing_message_fifo_unit.sv]
// Bounded queue of up to QUEUE_DEPTH short messages (16-bit kind, 16-bit sender id,
// up to PAYLOAD_MAX bytes) with coalescing. An add comes in as a run of items, one
// payload byte each, closed by tlast; a replace add overwrites the oldest stored
// message of the same kind, else appends. The last item of an add run gives one
// status item (added or rejected when full); a take gives the oldest message byte by
// byte, or one empty status item. The block is busy while it works on an item and takes
// no new one: an add item inside a run writes its byte, and the last item of a run also
// loads its status item; the first item of a plain add first opens a slot at the tail,
// and the first item of a replace add first compares the stored kinds one at a time,
// oldest first (up to QUEUE_DEPTH compares, set by the single kind compare against the
// kind memory), and opens a slot when none matches; a take reads the head metadata and
// then gives one result item at a time. A stalled output holds the block as well.
module coalescing_message_fifo_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PAYLOAD_MAX = 58
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input item stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // message_kind[15:0], remote_id[31:16], payload_byte[39:32]
    input  logic [cmf_pkg::TDATA_W-1:0] s_axis_tdata,
    // action[1:0], byte_valid[2]
    input  logic [cmf_pkg::TUSER_W-1:0] s_axis_tuser,
    // byte_last
    input  logic                        s_axis_tlast,
    // result item stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_kind[15:0], out_remote_id[31:16], out_byte[39:32]
    output logic [cmf_pkg::TDATA_W-1:0] m_axis_tdata,
    // status[1:0], out_byte_valid[2]
    output logic [cmf_pkg::TUSER_W-1:0] m_axis_tuser,
    // out_last
    output logic                        m_axis_tlast
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(PAYLOAD_MAX + 1);
    localparam int BYTE_DEPTH = QUEUE_DEPTH * PAYLOAD_MAX;
    localparam int AW = $clog2(BYTE_DEPTH);

    // control state
    cmf_pkg::t_state r_state, n_state;
    logic [QW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [QW-1:0] r_run_slot, n_run_slot;
    logic          r_run_open, n_run_open;
    logic          r_run_rej, n_run_rej;
    logic [LW-1:0] r_fill, n_fill;
    logic          r_out_valid;

    // working registers
    logic [QW-1:0]           r_slot, n_slot;
    logic [QW-1:0]           r_pos, n_pos;
    logic [AW-1:0]           r_base, n_base;
    logic [LW-1:0]           r_take_idx, n_take_idx;
    cmf_pkg::t_status        r_res_status, n_res_status;
    logic [cmf_pkg::KIND_W-1:0] r_kind;
    logic [cmf_pkg::ID_W-1:0]   r_sender;
    logic [cmf_pkg::BYTE_W-1:0] r_byte;
    logic                    r_bvalid;
    logic                    r_last;

    // output register payload
    cmf_pkg::t_status           r_out_status, n_out_status;
    logic [cmf_pkg::KIND_W-1:0] r_out_kind, n_out_kind;
    logic [cmf_pkg::ID_W-1:0]   r_out_sender, n_out_sender;
    logic [cmf_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                       r_out_bvalid, n_out_bvalid;
    logic                       r_out_last, n_out_last;
    logic                       out_load;
    logic                       out_free;

    // memory ports
    logic                       meta_we;
    logic [QW-1:0]              meta_waddr;
    logic                       meta_re;
    logic [QW-1:0]              meta_raddr;
    logic                       len_we;
    logic [cmf_pkg::KIND_W-1:0] kind_rd;
    logic [cmf_pkg::ID_W-1:0]   sender_rd;
    logic [LW-1:0]              len_rd;
    logic                       byte_we;
    logic [AW-1:0]              byte_waddr;
    logic                       byte_re;
    logic [AW-1:0]              byte_raddr;
    logic [cmf_pkg::BYTE_W-1:0] byte_rd;
    logic [LW-1:0]              n_fill_len;

    // shared slot unit and base multiplier
    logic [CW-1:0] unit_offset;
    logic [QW-1:0] unit_slot;
    logic [QW-1:0] mult_slot;
    logic [AW-1:0] mult_base;

    logic          in_accept;
    cmf_pkg::t_action in_action;
    logic [LW-1:0] len_sat;
    logic          take_last;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_action = cmf_pkg::t_action'(s_axis_tuser[1:0]);
    assign out_free  = !r_out_valid || m_axis_tready;
    assign mult_base = AW'(AW'(mult_slot) * AW'(PAYLOAD_MAX));
    assign len_sat   = (len_rd > LW'(PAYLOAD_MAX)) ? LW'(PAYLOAD_MAX) : len_rd;
    assign take_last = (len_sat == '0) || ((r_take_idx + LW'(1)) == len_sat);

    cmf_slot_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_slot_unit (
        .i_base  (r_head),
        .i_offset(unit_offset),
        .o_slot  (unit_slot)
    );

    cmf_ram #(
        .WIDTH(cmf_pkg::KIND_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_kind_ram (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(meta_waddr),
        .i_wdata(r_kind),
        .i_re   (meta_re),
        .i_raddr(meta_raddr),
        .o_rdata(kind_rd)
    );

    cmf_ram #(
        .WIDTH(cmf_pkg::ID_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_sender_ram (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(meta_waddr),
        .i_wdata(r_sender),
        .i_re   (meta_re),
        .i_raddr(meta_raddr),
        .o_rdata(sender_rd)
    );

    cmf_ram #(
        .WIDTH(LW),
        .DEPTH(QUEUE_DEPTH)
    ) u_length_ram (
        .i_clk  (i_clk),
        .i_we   (len_we),
        .i_waddr(r_run_slot),
        .i_wdata(n_fill_len),
        .i_re   (meta_re),
        .i_raddr(meta_raddr),
        .o_rdata(len_rd)
    );

    cmf_ram #(
        .WIDTH(cmf_pkg::BYTE_W),
        .DEPTH(BYTE_DEPTH)
    ) u_byte_ram (
        .i_clk  (i_clk),
        .i_we   (byte_we),
        .i_waddr(byte_waddr),
        .i_wdata(r_byte),
        .i_re   (byte_re),
        .i_raddr(byte_raddr),
        .o_rdata(byte_rd)
    );

    // length of the closing run, counting a byte stored by the last item
    assign n_fill_len = byte_we ? (r_fill + LW'(1)) : r_fill;

    // sequencer: next state, memory controls and result loading
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_run_slot   = r_run_slot;
        n_run_open   = r_run_open;
        n_run_rej    = r_run_rej;
        n_fill       = r_fill;
        n_slot       = r_slot;
        n_pos        = r_pos;
        n_base       = r_base;
        n_take_idx   = r_take_idx;
        n_res_status = r_res_status;
        n_out_status = cmf_pkg::ST_ADDED;
        n_out_kind   = '0;
        n_out_sender = '0;
        n_out_byte   = '0;
        n_out_bvalid = 1'b0;
        n_out_last   = 1'b1;
        out_load     = 1'b0;
        meta_we      = 1'b0;
        meta_waddr   = unit_slot;
        meta_re      = 1'b0;
        meta_raddr   = unit_slot;
        len_we       = 1'b0;
        byte_we      = 1'b0;
        byte_waddr   = r_base + AW'(r_fill);
        byte_re      = 1'b0;
        byte_raddr   = r_base;
        unit_offset  = '0;
        mult_slot    = r_head;
        s_axis_tready = 1'b0;

        case (r_state)
            cmf_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_accept) begin
                    if (r_run_open) begin
                        n_state = cmf_pkg::S_BYTE;
                    end else begin
                        case (in_action)
                            cmf_pkg::ACT_TAKE: begin
                                if (r_count == '0) begin
                                    n_res_status = cmf_pkg::ST_EMPTY;
                                    n_state      = cmf_pkg::S_RESULT;
                                end else begin
                                    // read metadata of the head slot
                                    meta_re = 1'b1;
                                    n_base  = mult_base;
                                    n_state = cmf_pkg::S_TAKE_RD;
                                end
                            end
                            cmf_pkg::ACT_REPLACE: begin
                                if (r_count == '0) begin
                                    n_state = cmf_pkg::S_OPEN_NEW;
                                end else begin
                                    // fetch the oldest kind
                                    meta_re = 1'b1;
                                    n_slot  = unit_slot;
                                    n_pos   = '0;
                                    n_state = cmf_pkg::S_SEARCH;
                                end
                            end
                            cmf_pkg::ACT_ADD: begin
                                n_state = cmf_pkg::S_OPEN_NEW;
                            end
                            default: begin
                                n_state = cmf_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end

            cmf_pkg::S_SEARCH: begin
                mult_slot   = r_slot;
                unit_offset = CW'(r_pos) + CW'(1);
                if (kind_rd == r_kind) begin
                    // overwrite the matching message in place
                    meta_we    = 1'b1;
                    meta_waddr = r_slot;
                    n_run_slot = r_slot;
                    n_base     = mult_base;
                    n_run_open = 1'b1;
                    n_run_rej  = 1'b0;
                    n_fill     = '0;
                    n_state    = cmf_pkg::S_BYTE;
                end else if ((CW'(r_pos) + CW'(1)) == r_count) begin
                    n_state = cmf_pkg::S_OPEN_NEW;
                end else begin
                    meta_re = 1'b1;
                    n_slot  = unit_slot;
                    n_pos   = r_pos + QW'(1);
                end
            end

            cmf_pkg::S_OPEN_NEW: begin
                unit_offset = r_count;
                mult_slot   = unit_slot;
                n_run_open  = 1'b1;
                n_fill      = '0;
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_run_rej  = 1'b1;
                    n_run_slot = '0;
                end else begin
                    // append at the tail
                    meta_we    = 1'b1;
                    n_count    = r_count + CW'(1);
                    n_run_slot = unit_slot;
                    n_base     = mult_base;
                    n_run_rej  = 1'b0;
                end
                n_state = cmf_pkg::S_BYTE;
            end

            cmf_pkg::S_BYTE: begin
                if (!r_run_rej && r_bvalid && (r_fill < LW'(PAYLOAD_MAX))) begin
                    byte_we = 1'b1;
                    n_fill  = r_fill + LW'(1);
                end
                if (r_last) begin
                    n_run_open = 1'b0;
                    n_fill     = '0;
                    if (r_run_rej) begin
                        n_run_rej    = 1'b0;
                        n_res_status = cmf_pkg::ST_REJECTED;
                    end else begin
                        len_we       = 1'b1;
                        n_res_status = cmf_pkg::ST_ADDED;
                    end
                    n_state = cmf_pkg::S_RESULT;
                end else begin
                    n_state = cmf_pkg::S_IDLE;
                end
            end

            cmf_pkg::S_RESULT: begin
                n_out_status = r_res_status;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = cmf_pkg::S_IDLE;
                end
            end

            cmf_pkg::S_TAKE_RD: begin
                // first byte of the head message
                byte_re    = 1'b1;
                n_take_idx = '0;
                n_state    = cmf_pkg::S_TAKE_OUT;
            end

            cmf_pkg::S_TAKE_OUT: begin
                unit_offset  = CW'(1);
                n_out_status = cmf_pkg::ST_BYTE_OUT;
                n_out_kind   = kind_rd;
                n_out_sender = sender_rd;
                n_out_bvalid = (len_sat != '0);
                n_out_byte   = (len_sat != '0) ? byte_rd : '0;
                n_out_last   = take_last;
                byte_raddr   = r_base + AW'(r_take_idx) + AW'(1);
                if (out_free) begin
                    out_load = 1'b1;
                    if (take_last) begin
                        n_head  = unit_slot;
                        n_count = r_count - CW'(1);
                        n_state = cmf_pkg::S_IDLE;
                    end else begin
                        byte_re    = 1'b1;
                        n_take_idx = r_take_idx + LW'(1);
                    end
                end
            end

            default: begin
                n_state = cmf_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmf_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_run_slot  <= '0;
            r_run_open  <= 1'b0;
            r_run_rej   <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_run_slot <= n_run_slot;
            r_run_open <= n_run_open;
            r_run_rej  <= n_run_rej;
            r_fill     <= n_fill;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_pos        <= n_pos;
        r_base       <= n_base;
        r_take_idx   <= n_take_idx;
        r_res_status <= n_res_status;
        if (in_accept) begin
            r_kind   <= s_axis_tdata[15:0];
            r_sender <= s_axis_tdata[31:16];
            r_byte   <= s_axis_tdata[39:32];
            r_bvalid <= s_axis_tuser[2];
            r_last   <= s_axis_tlast;
        end
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_kind   <= n_out_kind;
            r_out_sender <= n_out_sender;
            r_out_byte   <= n_out_byte;
            r_out_bvalid <= n_out_bvalid;
            r_out_last   <= n_out_last;
        end
    end

    // result item stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_byte, r_out_sender, r_out_kind};
    assign m_axis_tuser  = {r_out_bvalid, r_out_status};
    assign m_axis_tlast  = r_out_last;

endmodule
